FILE: rtl/core/tulc_pkg.sv
// Package for the tagged UID line checker: widths, status codes,
// parse-time constants and character helper functions. No dependencies.
package tulc_pkg;

    localparam int unsigned MAX_COUNTER_CHARS = 16;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd1000;
    localparam int unsigned UID_DIGITS = 8;

    localparam logic [3:0] ST_OK          = 4'd0;
    localparam logic [3:0] ST_EMPTY       = 4'd1;
    localparam logic [3:0] ST_BAD_FORMAT  = 4'd2;
    localparam logic [3:0] ST_BAD_UID     = 4'd3;
    localparam logic [3:0] ST_BAD_CS_LEN  = 4'd4;
    localparam logic [3:0] ST_BAD_COUNTER = 4'd5;
    localparam logic [3:0] ST_CS_MISMATCH = 4'd6;
    localparam logic [3:0] ST_DEBOUNCED   = 4'd7;
    localparam logic [3:0] ST_CTR_LONG    = 4'd8;

    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_BAR     = 8'h7C;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
    endfunction

    function automatic logic [7:0] prefix_char(input logic [1:0] pos);
        logic [7:0] r;
        case (pos)
            2'd0: r = 8'h55;
            2'd1: r = 8'h49;
            2'd2: r = 8'h44;
            default: r = CH_BAR;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        return (v < 4'd10) ? 8'd48 + {4'd0, v} : 8'd55 + {4'd0, v};
    endfunction

endpackage

FILE: rtl/core/tulc_if.sv
// Valid/ready channel interfaces for the tagged UID line checker:
// input items, result items and the configuration write. Depends on nothing.
interface tulc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] data_byte;
    modport source (output valid, output mode, output data_byte, input ready);
    modport sink (input valid, input mode, input data_byte, output ready);
endinterface

interface tulc_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic [3:0]  status;
    logic [31:0] uid_value;
    modport source (output valid, output accepted, output status, output uid_value,
                    input ready);
    modport sink (input valid, input accepted, input status, input uid_value,
                  output ready);
endinterface

interface tulc_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/tagged_uid_line_checker_top.sv
// Top level of the tagged UID line checker: line parser, counter memory, result register.
// Depends on tulc_pkg and the channel interfaces in tulc_if.sv.
//
// Takes one byte or tick transaction every clock cycle and returns one result per
// newline, registered in the cycle after the newline is taken. Input stalls only
// while a result waits and the sink is not ready. Counter characters live in one
// two-bank memory (current and previous counter); each character is compared against
// the previous counter as it arrives, using a registered read of the next position,
// and storing a counter just flips the bank pointer. No clearing pass after reset.
module tagged_uid_line_checker_top #(
    parameter int unsigned MAX_COUNTER_CHARS = tulc_pkg::MAX_COUNTER_CHARS
) (
    input  logic       clk,
    input  logic       rst_n,
    tulc_in_if.sink    in_ch,
    tulc_out_if.source out_ch,
    tulc_cfg_if.sink   cfg
);
    localparam int unsigned IW = (MAX_COUNTER_CHARS > 1) ? $clog2(MAX_COUNTER_CHARS) : 1;
    localparam int unsigned CW = $clog2(MAX_COUNTER_CHARS + 2);
    localparam int unsigned DEPTH = 2 * (2 ** IW);
    localparam logic [CW-1:0] MAXC = CW'(MAX_COUNTER_CHARS);

    typedef enum logic [2:0] {PH_PREFIX, PH_UID, PH_CS, PH_CTR, PH_BAD} phase_t;

    phase_t        phase_reg, phase_next;
    logic [2:0]    pos_reg, pos_next;
    logic          pend_reg, pend_next;
    logic [31:0]   uid_reg, uid_next;
    logic [3:0]    ucnt_reg, ucnt_next;
    logic          ubad_reg, ubad_next;
    logic [7:0]    sum_reg, sum_next;
    logic [15:0]   cs_reg, cs_next;
    logic [2:0]    ccnt_reg, ccnt_next;
    logic [CW-1:0] clen_reg, clen_next;
    logic [CW-1:0] raw_reg, raw_next;
    logic [CW-1:0] plen_reg, plen_next;
    logic          mm_reg, mm_next;
    logic [CW-1:0] fm_reg, fm_next;
    logic          bank_reg, bank_next;
    logic [31:0]   last_uid_reg, last_uid_next;
    logic          luv_reg, luv_next;
    logic [15:0]   ms_reg, ms_next;
    logic [15:0]   deb_reg;

    logic          ov_reg;
    logic          oacc_reg;
    logic [3:0]    ost_reg;
    logic [31:0]   ouid_reg;
    logic          res_fire;
    logic [3:0]    res_status;
    logic [31:0]   res_uid;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          wr_en;
    logic [IW:0]   wr_addr;
    logic [IW:0]   rd_addr;
    logic [7:0]    c;
    logic          take;
    logic          sp;
    logic [15:0]   expect_cs;

    assign in_ch.ready = !ov_reg || out_ch.ready;
    assign cfg.ready = 1'b1;
    assign take = in_ch.valid && in_ch.ready;
    assign c = tulc_pkg::to_upper(in_ch.data_byte);
    assign sp = tulc_pkg::is_space(c);
    assign expect_cs = {tulc_pkg::hex_char(sum_reg[7:4]), tulc_pkg::hex_char(sum_reg[3:0])};

    assign out_ch.valid = ov_reg;
    assign out_ch.accepted = oacc_reg;
    assign out_ch.status = ost_reg;
    assign out_ch.uid_value = ouid_reg;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next = pos_reg;
        pend_next = pend_reg;
        uid_next = uid_reg;
        ucnt_next = ucnt_reg;
        ubad_next = ubad_reg;
        sum_next = sum_reg;
        cs_next = cs_reg;
        ccnt_next = ccnt_reg;
        clen_next = clen_reg;
        raw_next = raw_reg;
        plen_next = plen_reg;
        mm_next = mm_reg;
        fm_next = fm_reg;
        bank_next = bank_reg;
        last_uid_next = last_uid_reg;
        luv_next = luv_reg;
        ms_next = ms_reg;
        wr_en = 1'b0;
        wr_addr = {!bank_reg, raw_reg[IW-1:0]};
        res_fire = 1'b0;
        res_status = tulc_pkg::ST_OK;
        res_uid = '0;
        if (take && in_ch.mode) begin
            if (ms_reg != 16'hFFFF) begin
                ms_next = ms_reg + 16'd1;
            end
        end else if (take && in_ch.data_byte == tulc_pkg::CH_NEWLINE) begin
            res_fire = 1'b1;
            if (phase_reg == PH_PREFIX && pos_reg == 3'd0) begin
                res_status = tulc_pkg::ST_EMPTY;
            end else if (phase_reg != PH_CS && phase_reg != PH_CTR) begin
                res_status = tulc_pkg::ST_BAD_FORMAT;
            end else if (ubad_reg || ucnt_reg != 4'(tulc_pkg::UID_DIGITS)) begin
                res_status = tulc_pkg::ST_BAD_UID;
            end else if (ccnt_reg != 3'd2) begin
                res_status = tulc_pkg::ST_BAD_CS_LEN;
            end else if (phase_reg == PH_CTR && clen_reg == '0) begin
                res_status = tulc_pkg::ST_BAD_COUNTER;
            end else if (phase_reg == PH_CTR && clen_reg > MAXC) begin
                res_status = tulc_pkg::ST_CTR_LONG;
            end else if (phase_reg == PH_CTR && clen_reg == plen_reg
                         && (!mm_reg || fm_reg >= clen_reg)) begin
                res_status = tulc_pkg::ST_BAD_COUNTER;
            end else if (cs_reg != expect_cs) begin
                res_status = tulc_pkg::ST_CS_MISMATCH;
            end else begin
                if (phase_reg == PH_CTR) begin
                    // the current bank becomes the previous counter
                    bank_next = !bank_reg;
                    plen_next = clen_reg;
                end
                res_uid = uid_reg;
                if (luv_reg && uid_reg == last_uid_reg && ms_reg < deb_reg) begin
                    res_status = tulc_pkg::ST_DEBOUNCED;
                end else begin
                    last_uid_next = uid_reg;
                    luv_next = 1'b1;
                    ms_next = '0;
                end
            end
            phase_next = PH_PREFIX;
            pos_next = '0;
            pend_next = 1'b0;
            uid_next = '0;
            ucnt_next = '0;
            ubad_next = 1'b0;
            sum_next = '0;
            cs_next = '0;
            ccnt_next = '0;
            clen_next = '0;
            raw_next = '0;
            mm_next = 1'b0;
            fm_next = '0;
        end else if (take) begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (!(pos_reg == 3'd0 && sp)) begin
                        if (c == tulc_pkg::prefix_char(pos_reg[1:0])) begin
                            pos_next = pos_reg + 3'd1;
                            if (pos_reg == 3'd3) begin
                                phase_next = PH_UID;
                            end
                        end else begin
                            phase_next = PH_BAD;
                        end
                    end
                end
                PH_UID:
                begin
                    if (c == tulc_pkg::CH_BAR) begin
                        phase_next = PH_CS;
                        pend_next = 1'b0;
                    end else if (sp) begin
                        if (ucnt_reg != '0) begin
                            pend_next = 1'b1;
                        end
                    end else begin
                        if (pend_reg) begin
                            ubad_next = 1'b1;
                        end
                        pend_next = 1'b0;
                        if (ucnt_reg < 4'd9) begin
                            ucnt_next = ucnt_reg + 4'd1;
                        end
                        sum_next = sum_reg + c;
                        if (c >= 8'h30 && c <= 8'h39) begin
                            uid_next = {uid_reg[27:0], 4'(c - 8'd48)};
                        end else if (c >= 8'h41 && c <= 8'h46) begin
                            uid_next = {uid_reg[27:0], 4'(c - 8'd55)};
                        end else begin
                            ubad_next = 1'b1;
                        end
                    end
                end
                PH_CS:
                begin
                    if (c == tulc_pkg::CH_BAR) begin
                        phase_next = PH_CTR;
                    end else if (sp) begin
                        if (ccnt_reg != '0) begin
                            pend_next = 1'b1;
                        end
                    end else begin
                        pend_next = 1'b0;
                        if (ccnt_reg < 3'd2 && !(pend_reg && ccnt_reg == 3'd1)) begin
                            cs_next = {cs_reg[7:0], c};
                        end else if (ccnt_reg < 3'd2 && pend_reg) begin
                            cs_next = cs_reg;
                        end
                        if (pend_reg) begin
                            ccnt_next = (ccnt_reg >= 3'd5) ? 3'd7 : ccnt_reg + 3'd2;
                            if (ccnt_reg == 3'd0) begin
                                cs_next = {cs_reg[7:0], c};
                            end
                        end else if (ccnt_reg < 3'd7) begin
                            ccnt_next = ccnt_reg + 3'd1;
                        end
                    end
                end
                PH_CTR:
                begin
                    if (!(sp && clen_reg == '0)) begin
                        if (raw_reg < MAXC) begin
                            wr_en = 1'b1;
                            // read data holds the previous counter at this position
                            if (raw_reg < plen_reg && rdata_reg != c && !mm_reg) begin
                                mm_next = 1'b1;
                                fm_next = raw_reg;
                            end
                        end
                        if (raw_reg <= MAXC) begin
                            raw_next = raw_reg + CW'(1);
                        end
                        if (!sp) begin
                            clen_next = (raw_reg <= MAXC) ? raw_reg + CW'(1) : raw_reg;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rd_addr = {bank_next, raw_next[IW-1:0]};

    always_ff @(posedge clk)
    begin
        if (wr_en) begin
            mem[wr_addr] <= c;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PH_PREFIX;
            pos_reg <= '0;
            pend_reg <= 1'b0;
            uid_reg <= '0;
            ucnt_reg <= '0;
            ubad_reg <= 1'b0;
            sum_reg <= '0;
            cs_reg <= '0;
            ccnt_reg <= '0;
            clen_reg <= '0;
            raw_reg <= '0;
            plen_reg <= '0;
            mm_reg <= 1'b0;
            fm_reg <= '0;
            bank_reg <= 1'b0;
            last_uid_reg <= '0;
            luv_reg <= 1'b0;
            ms_reg <= '0;
            deb_reg <= tulc_pkg::DEBOUNCE_RESET;
            ov_reg <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            pos_reg <= pos_next;
            pend_reg <= pend_next;
            uid_reg <= uid_next;
            ucnt_reg <= ucnt_next;
            ubad_reg <= ubad_next;
            sum_reg <= sum_next;
            cs_reg <= cs_next;
            ccnt_reg <= ccnt_next;
            clen_reg <= clen_next;
            raw_reg <= raw_next;
            plen_reg <= plen_next;
            mm_reg <= mm_next;
            fm_reg <= fm_next;
            bank_reg <= bank_next;
            last_uid_reg <= last_uid_next;
            luv_reg <= luv_next;
            ms_reg <= ms_next;
            if (cfg.valid) begin
                deb_reg <= cfg.data;
            end
            if (res_fire) begin
                ov_reg <= 1'b1;
            end else if (out_ch.ready) begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_fire) begin
            oacc_reg <= (res_status == tulc_pkg::ST_OK);
            ost_reg <= res_status;
            ouid_reg <= res_uid;
        end
    end

endmodule
